// File: hdl/etc_pkg.sv
// ----------------------------------------------------------------------------
// etc_pkg: shared types and constants of the event timer table
// Slot count, field widths, operation and result codes, slot entry layout.
// ----------------------------------------------------------------------------
package etc_pkg;

  // table geometry
  localparam int unsigned SLOTS    = 16;
  localparam int unsigned IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);

  // field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned DUR_S_W  = 16;
  localparam int unsigned DUR_MS_W = 27;
  localparam int unsigned KIND_W   = 3;

  localparam int unsigned MS_PER_S = 1000;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED  = 3'd0,
    KIND_FULL   = 3'd1,
    KIND_FIRED  = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_ANSWER = 3'd4
  } kind_e;

  // one stored timer
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   start;
    logic [DUR_MS_W-1:0] dur_ms;
    logic                periodic;
  } slot_t;

  // compare unit verdict
  typedef struct packed {
    logic due;
    logic match;
  } cmp_t;

endpackage

// File: hdl/etc_slot_file.sv
// ----------------------------------------------------------------------------
// etc_slot_file: generic single-port-write RAM
// One write port and one read port with registered read data; WIDTH bits
// by DEPTH entries, contents undefined until written.
// ----------------------------------------------------------------------------
module etc_slot_file #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                             clk_i,
  input  logic                                             we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     waddr_i,
  input  logic [WIDTH-1:0]                                 wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     raddr_i,
  output logic [WIDTH-1:0]                                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // entry write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/etc_cmp_unit.sv
// ----------------------------------------------------------------------------
// etc_cmp_unit: shared arithmetic and compare unit
// Due test (33-bit start plus duration against now), id match and the
// seconds to milliseconds scaling for new timers.
// ----------------------------------------------------------------------------
module etc_cmp_unit
  import etc_pkg::*;
(
  input  slot_t                entry_i,
  input  logic [TIME_W-1:0]    now_i,
  input  logic [ID_W-1:0]      key_i,
  input  logic [DUR_S_W-1:0]   dur_s_i,
  output cmp_t                 cmp_o,
  output logic [DUR_MS_W-1:0]  dur_ms_o
);

  logic [TIME_W:0] deadline;

  // expiry time, one bit wider so it never wraps
  assign deadline = {1'b0, entry_i.start}
                  + {{(TIME_W + 1 - DUR_MS_W){1'b0}}, entry_i.dur_ms};

  assign cmp_o.due   = (deadline <= {1'b0, now_i});
  assign cmp_o.match = (entry_i.id == key_i);

  // seconds to milliseconds
  assign dur_ms_o = {{(DUR_MS_W - DUR_S_W){1'b0}}, dur_s_i} * DUR_MS_W'(MS_PER_S);

endmodule

// File: hdl/event_timer_table.sv
// ----------------------------------------------------------------------------
// event_timer_table: table of one-shot and periodic timers
// Stores timers in insertion order, fires due ones on a tick with in-place
// compaction of one-shot removals, and answers id presence queries.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  input    | in_valid_i, in_ready_o | opcode_i now_ms_i event_id_i
//           |                        | duration_s_i persist_i
//  output   | out_valid_o,out_ready_i| kind_o fired_id_o found_o last_o
//
//  a tick or query scans one slot per cycle through the shared compare
//  unit, unless a tick holds at a due timer; the slot RAM is addressed
//  with the next read pointer so its registered data is on time.
//  a tick walks read and write pointers together, so removal needs no
//  separate pass. every result passes through one output register; add,
//  a due timer and the final result wait while it is full and not taken.
//  rst_ni clears the table count and control; slot contents need no reset.
//  input is ready whenever the sequencer is idle, even with a result pending.
// ----------------------------------------------------------------------------
module event_timer_table
  import etc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [TIME_W-1:0]   now_ms_i,
  input  logic [ID_W-1:0]     event_id_i,
  input  logic [DUR_S_W-1:0]  duration_s_i,
  input  logic                persist_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KIND_W-1:0]   kind_o,
  output logic [ID_W-1:0]     fired_id_o,
  output logic                found_o,
  output logic                last_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    rd_q, rd_d;
  logic [CNT_W-1:0]    wr_q, wr_d;
  logic                hit_q, hit_d;

  op_e                 op_q;
  logic [TIME_W-1:0]   now_q;
  logic [ID_W-1:0]     id_q;
  logic [DUR_S_W-1:0]  dur_s_q;
  logic                persist_q;

  logic                out_valid_q, out_valid_d;
  kind_e               kind_q, kind_d;
  logic [ID_W-1:0]     out_id_q, out_id_d;
  logic                found_q, found_d;
  logic                last_q, last_d;

  logic                in_accept;
  logic                out_free;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  slot_t               wdata;
  slot_t               rdata;
  cmp_t                cmp;
  logic [DUR_MS_W-1:0] dur_ms;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // slot storage, read data registered, addressed by the next read pointer
  etc_slot_file #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_d[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // shared compare unit
  etc_cmp_unit u_cmp (
    .entry_i  (rdata),
    .now_i    (now_q),
    .key_i    (id_q),
    .dur_s_i  (dur_s_q),
    .cmp_o    (cmp),
    .dur_ms_o (dur_ms)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    out_id_d    = out_id_q;
    found_d     = found_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = wr_q[IDX_W-1:0];
    wdata       = rdata;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          rd_d  = '0;
          wr_d  = '0;
          hit_d = 1'b0;
          case (op_e'(opcode_i))
            OP_ADD:   state_d = ST_ADD;
            OP_TICK:  state_d = ST_SCAN;
            OP_QUERY: state_d = ST_SCAN;
            default:  state_d = ST_IDLE;
          endcase
        end
      end

      ST_ADD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_id_d    = '0;
          found_d     = 1'b0;
          last_d      = 1'b1;
          if (cnt_q == CNT_W'(SLOTS)) begin
            kind_d = KIND_FULL;
          end else begin
            kind_d         = KIND_ADDED;
            we             = 1'b1;
            waddr          = cnt_q[IDX_W-1:0];
            wdata.id       = id_q;
            wdata.start    = now_q;
            wdata.dur_ms   = dur_ms;
            wdata.periodic = persist_q;
            cnt_d          = cnt_q + CNT_W'(1);
          end
          state_d = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (rd_q == cnt_q) begin
          state_d = ST_DONE;
        end else if (op_q == OP_TICK) begin
          if (cmp.due) begin
            // fired timer: restart periodic, drop one-shot
            if (out_free) begin
              out_valid_d = 1'b1;
              kind_d      = KIND_FIRED;
              out_id_d    = rdata.id;
              found_d     = 1'b0;
              last_d      = 1'b0;
              rd_d        = rd_q + CNT_W'(1);
              if (rdata.periodic) begin
                we          = 1'b1;
                wdata.start = now_q;
                wr_d        = wr_q + CNT_W'(1);
              end
            end
          end else begin
            // pending timer: compact toward the write pointer
            we   = 1'b1;
            rd_d = rd_q + CNT_W'(1);
            wr_d = wr_q + CNT_W'(1);
          end
        end else begin
          hit_d = hit_q || cmp.match;
          rd_d  = rd_q + CNT_W'(1);
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          found_d     = 1'b0;
          if (op_q == OP_TICK) begin
            kind_d   = KIND_DONE;
            out_id_d = '0;
            cnt_d    = wr_q;
          end else begin
            kind_d   = KIND_ANSWER;
            out_id_d = id_q;
            found_d  = hit_q;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // transaction and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q      <= op_e'(opcode_i);
      now_q     <= now_ms_i;
      id_q      <= event_id_i;
      dur_s_q   <= duration_s_i;
      persist_q <= persist_i;
    end
    kind_q   <= kind_d;
    out_id_q <= out_id_d;
    found_q  <= found_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign fired_id_o  = out_id_q;
  assign found_o     = found_q;
  assign last_o      = last_q;

`ifndef ASSERT_OFF
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SLOTS))
    else $error("timer count above table size");

  a_ptr_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (wr_q <= rd_q && rd_q <= cnt_q))
    else $error("compaction pointers out of order");

  a_fired_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_FIRED) |-> (op_q == OP_TICK && !last_q))
    else $error("fired result outside a tick");

  a_state_hot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");
`endif

endmodule
